// ===== rtl/fcou_pkg.sv =====
// Shared types, command codes and constants of the fly camera orientation unit.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package fcou_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAN_DX,
      ST_WRAP,
      ST_PAN_DY,
      ST_COR_YAW,
      ST_COR_PITCH,
      ST_PROD,
      ST_MOVE,
      ST_DONE
   } state_type;

   localparam logic [3:0] CMD_PAN    = 4'd0;
   localparam logic [3:0] CMD_FWD    = 4'd1;
   localparam logic [3:0] CMD_BACK   = 4'd2;
   localparam logic [3:0] CMD_UP     = 4'd3;
   localparam logic [3:0] CMD_DOWN   = 4'd4;
   localparam logic [3:0] CMD_LEFT   = 4'd5;
   localparam logic [3:0] CMD_RIGHT  = 4'd6;
   localparam logic [3:0] CMD_TURN_L = 4'd7;
   localparam logic [3:0] CMD_TURN_R = 4'd8;
   localparam logic [3:0] CMD_SET    = 4'd9;
   localparam logic [3:0] CMD_QUERY  = 4'd10;

   localparam logic [1:0] CSR_PAN_SENS  = 2'd0;
   localparam logic [1:0] CSR_TRANS_SPD = 2'd1;
   localparam logic [1:0] CSR_ROT_SPD   = 2'd2;

   localparam logic signed [21:0] DEG_QUARTER = 22'sd23040;
   localparam logic signed [21:0] DEG_HALF    = 22'sd46080;
   localparam logic signed [21:0] DEG_3QUART  = 22'sd69120;
   localparam logic signed [21:0] DEG_FULL    = 22'sd92160;
   localparam logic signed [21:0] PITCH_LIMIT = 22'sd22784;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam int                 MUL_W       = 50;
   localparam int                 MUL_BITS    = 32;

   // Arctangent of 2^-i in units of 2^-16 degree.
   function automatic logic [21:0] atan_entry(input logic [4:0] i);
      logic [21:0] r;
      case (i)
         5'd0:  r = 22'd2949120;
         5'd1:  r = 22'd1740967;
         5'd2:  r = 22'd919879;
         5'd3:  r = 22'd466945;
         5'd4:  r = 22'd234379;
         5'd5:  r = 22'd117304;
         5'd6:  r = 22'd58666;
         5'd7:  r = 22'd29335;
         5'd8:  r = 22'd14668;
         5'd9:  r = 22'd7334;
         5'd10: r = 22'd3667;
         5'd11: r = 22'd1833;
         5'd12: r = 22'd917;
         5'd13: r = 22'd458;
         5'd14: r = 22'd229;
         5'd15: r = 22'd115;
         5'd16: r = 22'd57;
         5'd17: r = 22'd29;
         5'd18: r = 22'd14;
         5'd19: r = 22'd7;
         5'd20: r = 22'd4;
         5'd21: r = 22'd2;
         5'd22: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] sat_q14(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd16384) begin
         r = 16'sd16384;
      end else if (v < -36'sd16384) begin
         r = -16'sd16384;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fly_camera_orientation_unit.sv =====
// Fly camera orientation unit: yaw/pitch/position state, serial multiplier and
// iterative CORDIC sequenced by one state machine. Depends on fcou_pkg.
//
//   port group   direction   handshake          contents
//   req_*        in          valid / stall      command, pan offsets, vector
//   rsp_*        out         valid / stall      front, up, right, position
//   csr_*        in          valid / ready      register index, write data
//
// One item at a time. Set, query, up, down and unused commands go straight to done.
// Moves use the bit-serial multiplier once per component. Pan and turn cost two
// CORDIC runs, four products and the yaw wrap; pan adds two more products.
// Reset is synchronous; a finished beat waits in the output register under
// rsp_stall while the next request is already taken.
`default_nettype none

module fly_camera_orientation_unit #(
   parameter int POS_WIDTH    = 48,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_cmd,
   input  wire logic signed [15:0] req_pan_dx,
   input  wire logic signed [15:0] req_pan_dy,
   input  wire logic signed [47:0] req_vec_x,
   input  wire logic signed [47:0] req_vec_y,
   input  wire logic signed [47:0] req_vec_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_front_x,
   output logic signed [15:0]      rsp_front_y,
   output logic signed [15:0]      rsp_front_z,
   output logic signed [15:0]      rsp_up_x,
   output logic signed [15:0]      rsp_up_y,
   output logic signed [15:0]      rsp_up_z,
   output logic signed [15:0]      rsp_right_x,
   output logic signed [15:0]      rsp_right_z,
   output logic signed [47:0]      rsp_rel_x,
   output logic signed [47:0]      rsp_rel_y,
   output logic signed [47:0]      rsp_rel_z,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam int CorSteps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int MulW     = fcou_pkg::MUL_W;

   fcou_pkg::state_type state_ff, state_in;

   logic [3:0]                  cmd_ff, cmd_in;
   logic signed [15:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic signed [47:0]          vec_ff [3];
   logic signed [47:0]          vec_in [3];
   logic [15:0]                 sens_ff, sens_in;
   logic [31:0]                 speed_ff, speed_in;
   logic [14:0]                 rot_ff, rot_in;
   logic [16:0]                 yaw_ff, yaw_in;
   logic signed [15:0]          pitch_ff, pitch_in;
   logic signed [21:0]          wrap_ff, wrap_in;
   logic signed [POS_WIDTH-1:0] pos_ff [3];
   logic signed [POS_WIDTH-1:0] pos_in [3];
   logic signed [15:0]          front_ff [3];
   logic signed [15:0]          front_in [3];
   logic signed [15:0]          up_ff [3];
   logic signed [15:0]          up_in [3];
   logic signed [15:0]          rgt_ff [2];
   logic signed [15:0]          rgt_in [2];
   logic signed [15:0]          sy_ff, sy_in, cy_ff, cy_in, sp_ff, sp_in, cp_ff, cp_in;
   logic                        run_ff, run_in;
   logic [5:0]                  cnt_ff, cnt_in;
   logic [1:0]                  k_ff, k_in;
   logic signed [16:0]          areg_ff, areg_in;
   logic [31:0]                 breg_ff, breg_in;
   logic signed [MulW-1:0]      acc_ff, acc_in;
   logic signed [33:0]          crx_ff, crx_in, cry_ff, cry_in;
   logic signed [25:0]          crz_ff, crz_in;
   logic                        neg_ff, neg_in;
   logic signed [15:0]          ofront_ff [3];
   logic signed [15:0]          ofront_in [3];
   logic signed [15:0]          oup_ff [3];
   logic signed [15:0]          oup_in [3];
   logic signed [15:0]          orgt_ff [2];
   logic signed [15:0]          orgt_in [2];
   logic signed [47:0]          orel_ff [3];
   logic signed [47:0]          orel_in [3];
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                   accept, out_load, mul_fin, cor_fin;
   logic signed [16:0]     a_sel;
   logic [31:0]            b_sel;
   logic [5:0]             len_sel;
   logic signed [15:0]     pa, pb, pb_mag, comp;
   logic signed [MulW-1:0] r12, r14, dmove;
   logic signed [21:0]     ang, ang_p, ang_r, pitch_sum;
   logic signed [33:0]     xs, ys, xneg, yneg, xr, yr;
   logic signed [25:0]     atz;
   logic signed [15:0]     qprod;

   assign accept    = req_valid && (state_ff == fcou_pkg::ST_IDLE);
   assign req_stall = (state_ff != fcou_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign mul_fin   = run_ff && (cnt_ff == 6'd0);
   assign cor_fin   = run_ff && (cnt_ff == 6'(CorSteps));

   assign r12   = (acc_ff + MulW'(2048)) >>> 12;
   assign r14   = (acc_ff + MulW'(8192)) >>> 14;
   assign qprod = fcou_pkg::sat_q14(36'(r14));

   // Multiplier operands for the current state and component.
   always_comb begin
      pa      = cy_ff;
      pb      = cp_ff;
      case (k_ff)
         2'd0: begin
            pa = cy_ff;
            pb = cp_ff;
         end
         2'd1: begin
            pa = sy_ff;
            pb = cp_ff;
         end
         2'd2: begin
            pa = sp_ff;
            pb = cy_ff;
         end
         default: begin
            pa = sp_ff;
            pb = sy_ff;
         end
      endcase
      pb_mag = pb[15] ? -pb : pb;
      if (cmd_ff inside {fcou_pkg::CMD_FWD, fcou_pkg::CMD_BACK}) begin
         comp = front_ff[k_ff];
      end else begin
         comp = (k_ff == 2'd0) ? rgt_ff[0] : rgt_ff[1];
      end
      case (state_ff)
         fcou_pkg::ST_PAN_DX: begin
            a_sel   = 17'(dx_ff);
            b_sel   = 32'(sens_ff);
            len_sel = 6'd16;
         end
         fcou_pkg::ST_PAN_DY: begin
            a_sel   = 17'(dy_ff);
            b_sel   = 32'(sens_ff);
            len_sel = 6'd16;
         end
         fcou_pkg::ST_PROD: begin
            a_sel   = pb[15] ? -17'(pa) : 17'(pa);
            b_sel   = 32'($unsigned(pb_mag));
            len_sel = 6'd15;
         end
         default: begin
            a_sel   = 17'(comp);
            b_sel   = speed_ff;
            len_sel = 6'd32;
         end
      endcase
   end

   // CORDIC range reduction, one rotation step and result rounding; pitch sum and move sign.
   always_comb begin
      if (state_ff == fcou_pkg::ST_COR_YAW) begin
         ang = $signed({5'b0, yaw_ff});
      end else begin
         ang = 22'(pitch_ff);
      end
      ang_p = (ang < 22'sd0) ? ang + fcou_pkg::DEG_FULL : ang;
      if (ang_p > fcou_pkg::DEG_QUARTER && ang_p <= fcou_pkg::DEG_3QUART) begin
         ang_r = ang_p - fcou_pkg::DEG_HALF;
      end else if (ang_p > fcou_pkg::DEG_3QUART) begin
         ang_r = ang_p - fcou_pkg::DEG_FULL;
      end else begin
         ang_r = ang_p;
      end
      xs   = crx_ff >>> cnt_ff[4:0];
      ys   = cry_ff >>> cnt_ff[4:0];
      atz  = $signed({4'b0, fcou_pkg::atan_entry(cnt_ff[4:0])});
      xneg = neg_ff ? -crx_ff : crx_ff;
      yneg = neg_ff ? -cry_ff : cry_ff;
      xr   = (xneg + 34'sd32768) >>> 16;
      yr   = (yneg + 34'sd32768) >>> 16;
      pitch_sum = 22'(r12) + 22'(pitch_ff);
      if (cmd_ff inside {fcou_pkg::CMD_BACK, fcou_pkg::CMD_LEFT}) begin
         dmove = -r14;
      end else begin
         dmove = r14;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcou_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == fcou_pkg::CMD_PAN) begin
                  state_in = fcou_pkg::ST_PAN_DX;
               end else if (req_cmd inside {fcou_pkg::CMD_TURN_L, fcou_pkg::CMD_TURN_R}) begin
                  state_in = fcou_pkg::ST_WRAP;
               end else if (req_cmd inside {fcou_pkg::CMD_FWD, fcou_pkg::CMD_BACK,
                                            fcou_pkg::CMD_LEFT, fcou_pkg::CMD_RIGHT}) begin
                  state_in = fcou_pkg::ST_MOVE;
               end else begin
                  state_in = fcou_pkg::ST_DONE;
               end
            end
         end
         fcou_pkg::ST_PAN_DX: begin
            if (mul_fin) state_in = fcou_pkg::ST_WRAP;
         end
         fcou_pkg::ST_WRAP: begin
            if (wrap_ff >= 22'sd0 && wrap_ff < fcou_pkg::DEG_FULL) begin
               state_in = (cmd_ff == fcou_pkg::CMD_PAN) ? fcou_pkg::ST_PAN_DY
                                                        : fcou_pkg::ST_COR_YAW;
            end
         end
         fcou_pkg::ST_PAN_DY: begin
            if (mul_fin) state_in = fcou_pkg::ST_COR_YAW;
         end
         fcou_pkg::ST_COR_YAW: begin
            if (cor_fin) state_in = fcou_pkg::ST_COR_PITCH;
         end
         fcou_pkg::ST_COR_PITCH: begin
            if (cor_fin) state_in = fcou_pkg::ST_PROD;
         end
         fcou_pkg::ST_PROD: begin
            if (mul_fin && k_ff == 2'd3) state_in = fcou_pkg::ST_DONE;
         end
         fcou_pkg::ST_MOVE: begin
            if (mul_fin && k_ff == 2'd2) state_in = fcou_pkg::ST_DONE;
         end
         fcou_pkg::ST_DONE: begin
            if (out_load) state_in = fcou_pkg::ST_IDLE;
         end
         default: state_in = fcou_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cmd_in       = cmd_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      vec_in       = vec_ff;
      sens_in      = sens_ff;
      speed_in     = speed_ff;
      rot_in       = rot_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      wrap_in      = wrap_ff;
      pos_in       = pos_ff;
      front_in     = front_ff;
      up_in        = up_ff;
      rgt_in       = rgt_ff;
      sy_in        = sy_ff;
      cy_in        = cy_ff;
      sp_in        = sp_ff;
      cp_in        = cp_ff;
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      areg_in      = areg_ff;
      breg_in      = breg_ff;
      acc_in       = acc_ff;
      crx_in       = crx_ff;
      cry_in       = cry_ff;
      crz_in       = crz_ff;
      neg_in       = neg_ff;
      ofront_in    = ofront_ff;
      oup_in       = oup_ff;
      orgt_in      = orgt_ff;
      orel_in      = orel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         case (csr_index)
            fcou_pkg::CSR_PAN_SENS:  sens_in  = csr_wdata[15:0];
            fcou_pkg::CSR_TRANS_SPD: speed_in = csr_wdata;
            fcou_pkg::CSR_ROT_SPD:   rot_in   = csr_wdata[14:0];
            default: ;
         endcase
      end

      case (state_ff)
         fcou_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_cmd;
               dx_in     = req_pan_dx;
               dy_in     = req_pan_dy;
               vec_in[0] = req_vec_x;
               vec_in[1] = req_vec_y;
               vec_in[2] = req_vec_z;
               k_in      = 2'd0;
               run_in    = 1'b0;
               case (req_cmd)
                  fcou_pkg::CMD_UP: begin
                     pos_in[1] = pos_ff[1] + POS_WIDTH'(speed_ff);
                  end
                  fcou_pkg::CMD_DOWN: begin
                     pos_in[1] = pos_ff[1] - POS_WIDTH'(speed_ff);
                  end
                  fcou_pkg::CMD_SET: begin
                     pos_in[0] = POS_WIDTH'(req_vec_x);
                     pos_in[1] = POS_WIDTH'(req_vec_y);
                     pos_in[2] = POS_WIDTH'(req_vec_z);
                  end
                  fcou_pkg::CMD_TURN_L: begin
                     wrap_in = $signed({5'b0, yaw_ff}) - $signed({7'b0, rot_ff});
                  end
                  fcou_pkg::CMD_TURN_R: begin
                     wrap_in = $signed({5'b0, yaw_ff}) + $signed({7'b0, rot_ff});
                  end
                  default: ;
               endcase
            end
         end
         fcou_pkg::ST_WRAP: begin
            if (wrap_ff < 22'sd0) begin
               wrap_in = wrap_ff + fcou_pkg::DEG_FULL;
            end else if (wrap_ff >= fcou_pkg::DEG_FULL) begin
               wrap_in = wrap_ff - fcou_pkg::DEG_FULL;
            end else begin
               yaw_in = wrap_ff[16:0];
            end
         end
         fcou_pkg::ST_COR_YAW, fcou_pkg::ST_COR_PITCH: begin
            if (!run_ff) begin
               run_in = 1'b1;
               cnt_in = 6'd0;
               crx_in = fcou_pkg::CORDIC_GAIN;
               cry_in = 34'sd0;
               crz_in = 26'(ang_r) <<< 8;
               neg_in = (ang_p > fcou_pkg::DEG_QUARTER) && (ang_p <= fcou_pkg::DEG_3QUART);
            end else if (!cor_fin) begin
               cnt_in = cnt_ff + 6'd1;
               if (crz_ff >= 26'sd0) begin
                  crx_in = crx_ff - ys;
                  cry_in = cry_ff + xs;
                  crz_in = crz_ff - atz;
               end else begin
                  crx_in = crx_ff + ys;
                  cry_in = cry_ff - xs;
                  crz_in = crz_ff + atz;
               end
            end else begin
               run_in = 1'b0;
               if (state_ff == fcou_pkg::ST_COR_YAW) begin
                  cy_in     = fcou_pkg::sat_q14(36'(xr));
                  sy_in     = fcou_pkg::sat_q14(36'(yr));
                  rgt_in[0] = -fcou_pkg::sat_q14(36'(yr));
                  rgt_in[1] = -fcou_pkg::sat_q14(36'(xr));
               end else begin
                  cp_in       = fcou_pkg::sat_q14(36'(xr));
                  sp_in       = fcou_pkg::sat_q14(36'(yr));
                  front_in[1] = fcou_pkg::sat_q14(36'(yr));
                  up_in[1]    = fcou_pkg::sat_q14(36'(xr));
                  k_in        = 2'd0;
               end
            end
         end
         fcou_pkg::ST_PAN_DX, fcou_pkg::ST_PAN_DY, fcou_pkg::ST_PROD,
         fcou_pkg::ST_MOVE: begin
            if (!run_ff) begin
               run_in  = 1'b1;
               cnt_in  = len_sel;
               areg_in = a_sel;
               breg_in = b_sel << (6'(fcou_pkg::MUL_BITS) - len_sel);
               acc_in  = '0;
            end else if (!mul_fin) begin
               cnt_in  = cnt_ff - 6'd1;
               breg_in = breg_ff << 1;
               acc_in  = (acc_ff <<< 1) + (breg_ff[31] ? MulW'(areg_ff) : MulW'(0));
            end else begin
               run_in = 1'b0;
               case (state_ff)
                  fcou_pkg::ST_PAN_DX: begin
                     wrap_in = 22'(r12) + $signed({5'b0, yaw_ff});
                  end
                  fcou_pkg::ST_PAN_DY: begin
                     if (pitch_sum > fcou_pkg::PITCH_LIMIT) begin
                        pitch_in = 16'(fcou_pkg::PITCH_LIMIT);
                     end else if (pitch_sum < -fcou_pkg::PITCH_LIMIT) begin
                        pitch_in = -16'(fcou_pkg::PITCH_LIMIT);
                     end else begin
                        pitch_in = pitch_sum[15:0];
                     end
                  end
                  fcou_pkg::ST_PROD: begin
                     k_in = k_ff + 2'd1;
                     case (k_ff)
                        2'd0:    front_in[0] = qprod;
                        2'd1:    front_in[2] = -qprod;
                        2'd2:    up_in[0]    = -qprod;
                        default: up_in[2]    = qprod;
                     endcase
                  end
                  default: begin
                     pos_in[k_ff] = pos_ff[k_ff] + POS_WIDTH'(dmove);
                     if (cmd_ff inside {fcou_pkg::CMD_LEFT, fcou_pkg::CMD_RIGHT}) begin
                        k_in = 2'd2;
                     end else begin
                        k_in = k_ff + 2'd1;
                     end
                  end
               endcase
            end
         end
         fcou_pkg::ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               ofront_in    = front_ff;
               oup_in       = up_ff;
               orgt_in      = rgt_ff;
               for (int j = 0; j < 3; j++) begin
                  if (cmd_ff == fcou_pkg::CMD_QUERY) begin
                     orel_in[j] = 48'(pos_ff[j] - POS_WIDTH'(vec_ff[j]));
                  end else begin
                     orel_in[j] = 48'(pos_ff[j]);
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcou_pkg::ST_IDLE;
         sens_ff      <= 16'd6554;
         speed_ff     <= 32'd65536;
         rot_ff       <= 15'd256;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         pos_ff       <= '{default: '0};
         front_ff     <= '{16'sd16384, 16'sd0, 16'sd0};
         up_ff        <= '{16'sd0, 16'sd16384, 16'sd0};
         rgt_ff       <= '{16'sd0, -16'sd16384};
         run_ff       <= 1'b0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sens_ff      <= sens_in;
         speed_ff     <= speed_in;
         rot_ff       <= rot_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         pos_ff       <= pos_in;
         front_ff     <= front_in;
         up_ff        <= up_in;
         rgt_ff       <= rgt_in;
         run_ff       <= run_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      vec_ff    <= vec_in;
      wrap_ff   <= wrap_in;
      sy_ff     <= sy_in;
      cy_ff     <= cy_in;
      sp_ff     <= sp_in;
      cp_ff     <= cp_in;
      areg_ff   <= areg_in;
      breg_ff   <= breg_in;
      acc_ff    <= acc_in;
      crx_ff    <= crx_in;
      cry_ff    <= cry_in;
      crz_ff    <= crz_in;
      neg_ff    <= neg_in;
      ofront_ff <= ofront_in;
      oup_ff    <= oup_in;
      orgt_ff   <= orgt_in;
      orel_ff   <= orel_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_front_x = ofront_ff[0];
   assign rsp_front_y = ofront_ff[1];
   assign rsp_front_z = ofront_ff[2];
   assign rsp_up_x    = oup_ff[0];
   assign rsp_up_y    = oup_ff[1];
   assign rsp_up_z    = oup_ff[2];
   assign rsp_right_x = orgt_ff[0];
   assign rsp_right_z = orgt_ff[1];
   assign rsp_rel_x   = orel_ff[0];
   assign rsp_rel_y   = orel_ff[1];
   assign rsp_rel_z   = orel_ff[2];

endmodule

`default_nettype wire
